>>> sv/cao_pkg.sv
// ----------------------------------------------------------------------------
// cao_pkg: shared types and helpers for the admittance offset block
// beat structs, register indexes, lane step codes and saturation helpers
// ----------------------------------------------------------------------------
package cao_pkg;

  localparam int unsigned AXES       = 3;
  localparam int unsigned DIV_STEPS  = 40;
  localparam int unsigned LANE_STEPS = 5;

  // opcodes of an input beat
  localparam logic [1:0] OP_TARGET = 2'd0;
  localparam logic [1:0] OP_FORCE  = 2'd1;
  localparam logic [1:0] OP_TICK   = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_MODE    = 3'd0;
  localparam logic [2:0] REG_BIASCNT = 3'd1;
  localparam logic [2:0] REG_DT      = 3'd2;
  localparam logic [2:0] REG_IMASS   = 3'd3;
  localparam logic [2:0] REG_DAMP    = 3'd4;
  localparam logic [2:0] REG_STIFF   = 3'd5;
  localparam logic [2:0] REG_DBAND   = 3'd6;
  localparam logic [2:0] REG_LIMIT   = 3'd7;

  // integration lane steps
  localparam logic [2:0] LS_MUL = 3'd0;
  localparam logic [2:0] LS_NET = 3'd1;
  localparam logic [2:0] LS_ACC = 3'd2;
  localparam logic [2:0] LS_VEL = 3'd3;
  localparam logic [2:0] LS_POS = 3'd4;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [23:0] force_x;
    logic signed [23:0] force_y;
    logic signed [23:0] force_z;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] cmd_x;
    logic signed [31:0] cmd_y;
    logic signed [31:0] cmd_z;
    logic               admittance_applied;
  } out_item_t;

  typedef struct packed {
    logic       en;
    logic [2:0] step;
  } lane_ctrl_t;

  // saturate a signed value to 32 bits
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [63:0] hi;
    logic signed [63:0] lo;
    hi = 64'sd2147483647;
    lo = -64'sd2147483648;
    if (v > hi) return 32'sh7fffffff;
    else if (v < lo) return 32'sh80000000;
    else return v[31:0];
  endfunction

endpackage

>>> sv/cartesian_admittance_offset_top.sv
// ----------------------------------------------------------------------------
// cartesian_admittance_offset_top: three-axis admittance offset
// target and force beats are taken while idle; a force beat that completes
//   bias calibration starts a serial 40-step divider per axis
// tick with a target held: five lane steps plus result load before out_valid, result load
//   only when passed through; one beat in work, a held result stalls the load until out_ready
// reset: control state and offsets cleared, registers to defaults, no calibration sweep
// ----------------------------------------------------------------------------
module cartesian_admittance_offset_top
  import cao_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [47:0] cfg_wdata_i
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_INT  = 4'b0100,
    S_RES  = 4'b1000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [1:0]  mode_q;
  logic [15:0] bcnt_q;
  logic [23:0] dt_q;
  logic [47:0] imass_q, damp_q, stiff_q, dband_q, limit_q;

  logic signed [31:0] tgt_q  [AXES];
  logic signed [23:0] frc_q  [AXES];
  logic signed [39:0] bacc_q [AXES];
  logic signed [23:0] bias_q [AXES];
  logic signed [39:0] bacc_d [AXES];
  logic signed [23:0] frc_in [AXES];
  logic signed [23:0] quot   [AXES];
  logic signed [31:0] offs   [AXES];
  logic signed [31:0] cmd    [AXES];
  logic tgt_vld_q, frc_vld_q, bias_rdy_q, applied_q;
  logic [15:0] seen_q, seen_d;
  logic [2:0]  step_q;
  logic        in_acc, div_start, div_done, cal_hit;
  logic [AXES-1:0] dn;
  lane_ctrl_t  lctrl;
  logic        out_valid_q;
  out_item_t   out_q;

  assign in_ready_o = state_q == S_IDLE;
  assign in_acc     = in_valid_i && in_ready_o;
  assign frc_in[0]  = in_data_i.force_x;
  assign frc_in[1]  = in_data_i.force_y;
  assign frc_in[2]  = in_data_i.force_z;

  // calibration accumulate and completion check
  always_comb begin
    for (int a = 0; a < AXES; a++) bacc_d[a] = bacc_q[a] + 40'(frc_in[a]);
  end
  assign seen_d    = seen_q + 16'd1;
  assign cal_hit   = (seen_d >= bcnt_q) && (seen_d != '0);
  assign div_start = in_acc && in_data_i.opcode == OP_FORCE && mode_q[1] && !bias_rdy_q
                     && cal_hit;
  assign div_done  = &dn;

  assign lctrl.en   = state_q == S_INT;
  assign lctrl.step = step_q;

  for (genvar a = 0; a < AXES; a++) begin : g_lane
    cao_div u_div (
      .clk_i, .rst_ni,
      .start_i   (div_start),
      .dividend_i(bacc_d[a]),
      .divisor_i (seen_d),
      .done_o    (dn[a]),
      .quot_o    (quot[a])
    );
    cao_lane u_lane (
      .clk_i, .rst_ni,
      .ctrl_i  (lctrl),
      .force_i (frc_q[a]),
      .bias_i  (bias_q[a]),
      .imass_i (imass_q[16*a +: 16]),
      .damp_i  (damp_q[16*a +: 16]),
      .stiff_i (stiff_q[16*a +: 16]),
      .dband_i (dband_q[16*a +: 16]),
      .limit_i (limit_q[16*a +: 16]),
      .dt_i    (dt_q),
      .offset_o(offs[a])
    );
    assign cmd[a] = applied_q ? sat32(64'(tgt_q[a]) + 64'(offs[a])) : tgt_q[a];
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (div_start) state_d = S_DIV;
          else if (in_data_i.opcode == OP_TICK && tgt_vld_q) begin
            if (mode_q[0] && frc_vld_q && bias_rdy_q) state_d = S_INT;
            else state_d = S_RES;
          end
        end
      end
      S_DIV: if (div_done) state_d = S_IDLE;
      S_INT: if (step_q == 3'(LANE_STEPS - 1)) state_d = S_RES;
      S_RES: if (!out_valid_q || out_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      mode_q      <= 2'd3;
      bcnt_q      <= 16'd200;
      dt_q        <= 24'd83886;
      imass_q     <= 48'h0800_0800_0800;
      damp_q      <= 48'h1400_1400_1400;
      stiff_q     <= 48'h0780_0780_0780;
      dband_q     <= 48'h0200_0200_0200;
      limit_q     <= 48'h199a_199a_199a;
      tgt_vld_q   <= 1'b0;
      frc_vld_q   <= 1'b0;
      bias_rdy_q  <= 1'b0;
      seen_q      <= '0;
      applied_q   <= 1'b0;
      out_valid_q <= 1'b0;
      for (int a = 0; a < AXES; a++) begin
        tgt_q[a]  <= '0;
        frc_q[a]  <= '0;
        bacc_q[a] <= '0;
        bias_q[a] <= '0;
      end
    end else begin
      state_q <= state_d;
      // register writes
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_MODE:    mode_q  <= cfg_wdata_i[1:0];
          REG_BIASCNT: bcnt_q  <= cfg_wdata_i[15:0];
          REG_DT:      dt_q    <= cfg_wdata_i[23:0];
          REG_IMASS:   imass_q <= cfg_wdata_i;
          REG_DAMP:    damp_q  <= cfg_wdata_i;
          REG_STIFF:   stiff_q <= cfg_wdata_i;
          REG_DBAND:   dband_q <= cfg_wdata_i;
          REG_LIMIT:   limit_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      // input beat
      if (in_acc) begin
        case (in_data_i.opcode)
          OP_TARGET: begin
            tgt_q[0]  <= in_data_i.pos_x;
            tgt_q[1]  <= in_data_i.pos_y;
            tgt_q[2]  <= in_data_i.pos_z;
            tgt_vld_q <= 1'b1;
          end
          OP_FORCE: begin
            for (int a = 0; a < AXES; a++) frc_q[a] <= frc_in[a];
            frc_vld_q <= 1'b1;
            if (mode_q[1]) begin
              if (!bias_rdy_q) begin
                for (int a = 0; a < AXES; a++) bacc_q[a] <= bacc_d[a];
                seen_q <= seen_d;
              end
            end else begin
              bias_rdy_q <= 1'b1;
            end
          end
          OP_TICK: applied_q <= mode_q[0] && frc_vld_q && bias_rdy_q;
          default: ;
        endcase
      end
      // bias result
      if (state_q == S_DIV && div_done) begin
        for (int a = 0; a < AXES; a++) bias_q[a] <= quot[a];
        bias_rdy_q <= 1'b1;
      end
      // lane step counter
      if (state_q == S_INT) step_q <= step_q + 3'd1;
      else step_q <= '0;
      // output register
      if (state_q == S_RES && (!out_valid_q || out_ready_i)) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (state_q == S_RES && (!out_valid_q || out_ready_i)) begin
      out_q.cmd_x              <= cmd[0];
      out_q.cmd_y              <= cmd[1];
      out_q.cmd_z              <= cmd[2];
      out_q.admittance_applied <= applied_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> sv/cao_div.sv
// ----------------------------------------------------------------------------
// cao_div: serial signed divider for the force bias
// restoring division, one quotient bit per cycle, truncates toward zero
// ----------------------------------------------------------------------------
module cao_div
  import cao_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [39:0] dividend_i,
  input  logic [15:0]        divisor_i,
  output logic               done_o,
  output logic signed [23:0] quot_o
);

  logic        busy_q, done_q, neg_q;
  logic [5:0]  cnt_q;
  logic [39:0] dq_q;
  logic [15:0] rem_q, div_q;
  logic [16:0] rem_sh;
  logic        ge;
  logic [39:0] mag;

  // magnitude of the dividend
  assign mag    = dividend_i[39] ? 40'(-dividend_i) : 40'(dividend_i);
  // one restoring step
  assign rem_sh = {rem_q, dq_q[39]};
  assign ge     = rem_sh >= {1'b0, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= 6'(DIV_STEPS - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 6'd1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dq_q  <= mag;
      rem_q <= '0;
      div_q <= divisor_i;
      neg_q <= dividend_i[39];
    end else if (busy_q) begin
      rem_q <= ge ? 16'(rem_sh - {1'b0, div_q}) : rem_sh[15:0];
      dq_q  <= {dq_q[38:0], ge};
    end
  end

  assign done_o = done_q;
  assign quot_o = neg_q ? 24'(-dq_q[23:0]) : dq_q[23:0];

endmodule

>>> sv/cao_lane.sv
// ----------------------------------------------------------------------------
// cao_lane: one axis of the mass-spring-damper integrator
// five sequenced steps, two multiplies in the first and one in each of the last three,
// holds offset and velocity
module cao_lane
  import cao_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  lane_ctrl_t         ctrl_i,
  input  logic signed [23:0] force_i,
  input  logic signed [23:0] bias_i,
  input  logic [15:0]        imass_i,
  input  logic [15:0]        damp_i,
  input  logic [15:0]        stiff_i,
  input  logic [15:0]        dband_i,
  input  logic [15:0]        limit_i,
  input  logic [23:0]        dt_i,
  output logic signed [31:0] offset_o
);

  logic signed [31:0] x_q, v_q, vn_q;
  logic signed [24:0] f_q;
  logic signed [48:0] dv_q, kx_q;
  logic signed [46:0] net_q;
  logic signed [38:0] acc_q;

  logic signed [24:0] f_raw;
  logic [24:0]        f_abs;
  logic signed [52:0] net_sum;
  logic signed [63:0] p_acc, p_vel;
  logic signed [55:0] acc_full;
  logic signed [35:0] dv_inc;
  logic signed [56:0] p_pos;
  logic signed [32:0] dx_inc;
  logic signed [31:0] x_sat, x_clp;
  logic signed [20:0] lim;

  // biased force with deadband
  assign f_raw = 25'(force_i) - 25'(bias_i);
  assign f_abs = f_raw[24] ? 25'(-f_raw) : 25'(f_raw);

  // net force, LSB 2^-26 N
  assign net_sum = (53'(f_q) <<< 16) - 53'(dv_q) + (53'(kx_q) <<< 2);

  // acceleration, clamped to 39 bits
  assign p_acc    = 64'(net_q) * 64'($signed({1'b0, imass_i}));
  assign acc_full = 56'(p_acc >>> 8);

  // velocity increment
  assign p_vel  = 64'(acc_q) * 64'($signed({1'b0, dt_i}));
  assign dv_inc = 36'(p_vel >>> 28);

  // position increment and clamp
  assign p_pos  = 57'(vn_q) * 57'($signed({1'b0, dt_i}));
  assign dx_inc = 33'(p_pos >>> 24);
  assign x_sat  = sat32(64'(x_q) + 64'(dx_inc));
  assign lim    = $signed({1'b0, limit_i, 4'b0});
  always_comb begin
    if (32'(x_sat) > 32'(lim)) x_clp = 32'(lim);
    else if (32'(x_sat) < -32'(lim)) x_clp = -32'(lim);
    else x_clp = x_sat;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_q <= '0;
      v_q <= '0;
    end else if (ctrl_i.en && ctrl_i.step == LS_POS) begin
      x_q <= x_clp;
      if ((x_clp >= 32'(lim) && vn_q > 0) || (x_clp <= -32'(lim) && vn_q < 0)) v_q <= '0;
      else v_q <= vn_q;
    end
  end

  // step datapath
  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      case (ctrl_i.step)
        LS_MUL: begin
          f_q  <= (f_abs < {9'b0, dband_i}) ? '0 : f_raw;
          dv_q <= 49'($signed({1'b0, damp_i})) * 49'(v_q);
          kx_q <= 49'($signed({1'b0, stiff_i})) * 49'(x_q);
        end
        LS_NET: net_q <= 47'(net_sum >>> 6);
        LS_ACC: begin
          if (acc_full > 56'sh3f_ffff_ffff) acc_q <= 39'sh3f_ffff_ffff;
          else if (acc_full < -56'sh40_0000_0000) acc_q <= -39'sh40_0000_0000;
          else acc_q <= acc_full[38:0];
        end
        LS_VEL: vn_q <= sat32(64'(v_q) + 64'(dv_inc));
        default: ;
      endcase
    end
  end

  assign offset_o = x_q;

endmodule

>>> sv/cao_checker.sv
// ----------------------------------------------------------------------------
// cao_checker: port-level checks for the admittance offset block
// watches the two beat channels and binds to the top level
// ----------------------------------------------------------------------------
module cao_checker
  import cao_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input in_item_t  in_data_i,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input out_item_t out_data_o
);

  // a stalled result beat stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat dropped or changed while stalled");

  // a new result appears only when the input was not ready in the previous cycle
  a_out_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result appeared without a result load cycle");

  // a target beat leaves the input ready in the cycle after it is taken
  a_target_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.opcode == OP_TARGET |=> in_ready_o)
    else $error("target beat held the input channel");

  // target and unused beats never raise a result
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && in_data_i.opcode != OP_TICK && in_data_i.opcode != OP_FORCE
    |=> !$rose(out_valid_o))
    else $error("result produced by a non-tick beat");

endmodule

bind cartesian_admittance_offset_top cao_checker u_cao_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
  .out_valid_o, .out_ready_i, .out_data_o
);

>>> tb/cartesian_admittance_offset_top_test.sv
// ----------------------------------------------------------------------------
// cartesian_admittance_offset_top_test: admittance offset block testbench
// drives target, force, tick and unused beats, some with random gaps, predicts command beats
// with a fixed-point admittance model or from directed rows, and checks them field by field
// ----------------------------------------------------------------------------
module cartesian_admittance_offset_top_test;
  import cao_pkg::*;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  in_item_t    in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  out_item_t   out_data_o;
  logic        cfg_we_i;
  logic [2:0]  cfg_index_i;
  logic [47:0] cfg_wdata_i;

  cartesian_admittance_offset_top dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o, .cfg_we_i, .cfg_index_i, .cfg_wdata_i
  );

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 2000000;

  // clock
  initial clk_i = 1'b0;
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // predictor copy of registers and state
  logic [1:0]        m_mode;
  logic [15:0]       m_bias_cnt;
  logic [23:0]       m_dt;
  logic [47:0]       m_imass, m_damp, m_stiff, m_dband, m_limit;
  logic signed [31:0] m_target [3];
  logic              m_target_ok;
  logic signed [23:0] m_force [3];
  logic              m_force_ok;
  longint            m_accum [3];
  logic [15:0]       m_seen;
  logic signed [23:0] m_bias [3];
  logic              m_bias_ok;
  longint            m_offset [3];
  longint            m_vel [3];

  out_item_t cmd_queue [$];
  int        n_errors;
  int unsigned cycle_count;
  bit        hold_off_req;
  bit        in_long_hold;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    n_errors++;
  endtask

  function automatic longint floor_shr(input longint v, input int n);
    return v >>> n;
  endfunction

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  function automatic longint sat_w(input longint v);
    return clip(v, -64'sd2147483648, 64'sd2147483647);
  endfunction

  function automatic longint lane16(input logic [47:0] p, input int a);
    return longint'({48'd0, p[16*a +: 16]});
  endfunction

  task automatic reset_model();
    m_mode = 2'd3; m_bias_cnt = 16'd200; m_dt = 24'd83886;
    m_imass = 48'd8796227241984; m_damp = 48'd21990568104960;
    m_stiff = 48'd8246463039360; m_dband = 48'd2199056810496;
    m_limit = 48'd28149645187482;
    for (int a = 0; a < 3; a++) begin
      m_target[a] = '0; m_force[a] = '0; m_accum[a] = 0; m_bias[a] = '0;
      m_offset[a] = 0; m_vel[a] = 0;
    end
    m_target_ok = 0; m_force_ok = 0; m_seen = '0; m_bias_ok = 0;
  endtask

  // one admittance step on an axis
  function automatic void step_axis(input int a);
    longint f, x, v, dt, net, acc, lim;
    f = longint'(m_force[a]) - longint'(m_bias[a]);
    x = m_offset[a];
    v = m_vel[a];
    dt = longint'({40'd0, m_dt});
    if ((f < 0 ? -f : f) < lane16(m_dband, a)) f = 0;
    net = f * 65536 - lane16(m_damp, a) * v + lane16(m_stiff, a) * x * 4;
    net = floor_shr(net, 6);
    acc = floor_shr(net * lane16(m_imass, a), 8);
    acc = clip(acc, -(64'sd1 <<< 38), (64'sd1 <<< 38) - 1);
    v = sat_w(v + floor_shr(acc * dt, 28));
    x = sat_w(x + floor_shr(v * dt, 24));
    lim = lane16(m_limit, a) * 16;
    x = clip(x, -lim, lim);
    if (x >= lim && v > 0) v = 0;
    if (x <= -lim && v < 0) v = 0;
    m_offset[a] = x;
    m_vel[a] = v;
  endfunction

  // update the model for one accepted beat, return whether a command follows
  function automatic bit predict_cmd(input in_item_t it, output out_item_t res);
    longint c [3];
    res = '0;
    case (it.opcode)
      OP_TARGET: begin
        m_target[0] = it.pos_x; m_target[1] = it.pos_y; m_target[2] = it.pos_z;
        m_target_ok = 1;
        return 0;
      end
      OP_FORCE: begin
        m_force[0] = it.force_x; m_force[1] = it.force_y; m_force[2] = it.force_z;
        m_force_ok = 1;
        if (m_mode[1]) begin
          if (!m_bias_ok) begin
            for (int a = 0; a < 3; a++) m_accum[a] += longint'(m_force[a]);
            m_seen = m_seen + 16'd1;
            if (m_seen >= m_bias_cnt && m_seen != 0) begin
              for (int a = 0; a < 3; a++)
                m_bias[a] = 24'(m_accum[a] / longint'({48'd0, m_seen}));
              m_bias_ok = 1;
            end
          end
        end else begin
          m_bias_ok = 1;
        end
        return 0;
      end
      OP_TICK: begin
        if (!m_target_ok) return 0;
        if (!m_mode[0] || !m_force_ok || !m_bias_ok) begin
          res.cmd_x = m_target[0]; res.cmd_y = m_target[1]; res.cmd_z = m_target[2];
          res.admittance_applied = 1'b0;
          return 1;
        end
        for (int a = 0; a < 3; a++) begin
          step_axis(a);
          c[a] = sat_w(longint'(m_target[a]) + m_offset[a]);
        end
        res.cmd_x = 32'(c[0]); res.cmd_y = 32'(c[1]); res.cmd_z = 32'(c[2]);
        res.admittance_applied = 1'b1;
        return 1;
      end
      default: return 0;
    endcase
  endfunction

  // check each command beat against the oldest prediction
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (cmd_queue.size() == 0) begin
        report("unexpected beat cmd_x", out_data_o.cmd_x, 32'h0);
      end else begin
        want = cmd_queue.pop_front();
        if (out_data_o.cmd_x !== want.cmd_x) report("cmd_x", out_data_o.cmd_x, want.cmd_x);
        if (out_data_o.cmd_y !== want.cmd_y) report("cmd_y", out_data_o.cmd_y, want.cmd_y);
        if (out_data_o.cmd_z !== want.cmd_z) report("cmd_z", out_data_o.cmd_z, want.cmd_z);
        if (out_data_o.admittance_applied !== want.admittance_applied)
          report("applied", 32'(out_data_o.admittance_applied),
                 32'(want.admittance_applied));
      end
    end
  end

  // receiver stalls, plus a long hold-off on request
  initial begin
    int n;
    out_ready_i = 1'b0;
    in_long_hold = 0;
    @(posedge rst_ni);
    forever begin
      if (hold_off_req) begin
        in_long_hold = 1;
        out_ready_i <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_off_req = 0;
        in_long_hold = 0;
      end
      n = $urandom_range(0, 9);
      if (n == 9) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(10, 40)) @(posedge clk_i);
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= (n < 6);
      end
      @(posedge clk_i);
    end
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // drive one input beat and update the prediction on acceptance
  task automatic send_beat(input in_item_t it, input bit gaps);
    out_item_t res;
    int g;
    if (gaps) begin
      g = $urandom_range(0, 15);
      if (g > 12) g = $urandom_range(5, 30);
      else if (g > 3) g = 0;
      if (g > 0) begin
        in_valid_i <= 1'b0;
        repeat (g) @(posedge clk_i);
      end
    end
    in_valid_i <= 1'b1;
    in_data_i <= it;
    do @(posedge clk_i); while (!in_ready_o);
    if (predict_cmd(it, res)) cmd_queue.push_back(res);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (cmd_queue.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [47:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_MODE:    m_mode = val[1:0];
      REG_BIASCNT: m_bias_cnt = val[15:0];
      REG_DT:      m_dt = val[23:0];
      REG_IMASS:   m_imass = val;
      REG_DAMP:    m_damp = val;
      REG_STIFF:   m_stiff = val;
      REG_DBAND:   m_dband = val;
      REG_LIMIT:   m_limit = val;
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  function automatic in_item_t make_beat(input logic [1:0] op, input int sz);
    in_item_t it;
    it = '0;
    it.opcode = op;
    it.pos_x = $urandom; it.pos_y = $urandom; it.pos_z = $urandom;
    it.force_x = 24'($urandom); it.force_y = 24'($urandom); it.force_z = 24'($urandom);
    if (sz == 0) begin
      // moderate magnitudes keep the loop away from saturation most of the time
      it.pos_x = $signed(it.pos_x) >>> 8; it.pos_y = $signed(it.pos_y) >>> 8;
      it.pos_z = $signed(it.pos_z) >>> 8;
      it.force_x = $signed(it.force_x) >>> 10; it.force_y = $signed(it.force_y) >>> 10;
      it.force_z = $signed(it.force_z) >>> 10;
    end
    return it;
  endfunction

  function automatic logic [47:0] rand48();
    return 48'({$urandom, $urandom});
  endfunction

  // directed rows: opcode, fill pattern for positions/forces, checked result
  typedef struct {
    logic [1:0]  op;
    logic [31:0] pos;
    logic [23:0] frc;
    bit          has_want;
    out_item_t   want;
  } row_t;

  row_t rows [$];

  initial begin
    in_item_t  it;
    out_item_t res;
    bit        ok;
    int        kind;
    n_errors = 0;
    cycle_count = 0;
    hold_off_req = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    in_data_i = '0;
    cfg_we_i = 1'b0;
    cfg_index_i = REG_MODE;
    cfg_wdata_i = '0;
    reset_model();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed part, default registers then calibration shortened
    rows.push_back('{OP_TICK, 32'h0, 24'h0, 0, '0});
    rows.push_back('{OP_UNUSED, 32'h7fffffff, 24'h7fffff, 0, '0});
    rows.push_back('{OP_TARGET, 32'h7fffffff, 24'h0, 0, '0});
    rows.push_back('{OP_TICK, 32'h0, 24'h0, 1, '{32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 1'b0}});
    rows.push_back('{OP_TARGET, 32'h80000000, 24'h0, 0, '0});
    rows.push_back('{OP_TICK, 32'h0, 24'h0, 1, '{32'h80000000, 32'h80000000, 32'h80000000, 1'b0}});
    rows.push_back('{OP_FORCE, 32'h0, 24'h7fffff, 0, '0});
    rows.push_back('{OP_TICK, 32'h0, 24'h0, 1, '{32'h80000000, 32'h80000000, 32'h80000000, 1'b0}});
    foreach (rows[i]) begin
      it = '0;
      it.opcode = rows[i].op;
      it.pos_x = rows[i].pos; it.pos_y = rows[i].pos; it.pos_z = rows[i].pos;
      it.force_x = rows[i].frc; it.force_y = rows[i].frc; it.force_z = rows[i].frc;
      if (rows[i].has_want) begin
        cmd_queue.push_back(rows[i].want);
        send_beat(it, 0);
        void'(cmd_queue.pop_back());
      end else begin
        send_beat(it, 0);
      end
    end
    drain();
    // calibrate over two samples including the negative extreme
    write_reg(REG_BIASCNT, 48'd2);
    rows.delete();
    rows.push_back('{OP_FORCE, 32'h0, 24'h800000, 0, '0});
    rows.push_back('{OP_TARGET, 32'h0, 24'h0, 0, '0});
    rows.push_back('{OP_TICK, 32'h0, 24'h0, 0, '0});
    rows.push_back('{OP_FORCE, 32'h0, 24'h7fffff, 0, '0});
    rows.push_back('{OP_TICK, 32'h0, 24'h0, 0, '0});
    rows.push_back('{OP_FORCE, 32'h0, 24'h800000, 0, '0});
    rows.push_back('{OP_TICK, 32'h0, 24'h0, 0, '0});
    rows.push_back('{OP_TICK, 32'h0, 24'h0, 0, '0});
    foreach (rows[i]) begin
      it = '0;
      it.opcode = rows[i].op;
      it.force_x = rows[i].frc; it.force_y = rows[i].frc; it.force_z = rows[i].frc;
      send_beat(it, 0);
    end
    drain();
    // extremes of the registers: zero dt and mass, then full scale
    write_reg(REG_DT, 48'd0);
    write_reg(REG_IMASS, 48'd0);
    it = make_beat(OP_TICK, 1);
    send_beat(it, 0);
    drain();
    write_reg(REG_DT, 48'hffffff);
    write_reg(REG_IMASS, 48'hffffffffffff);
    write_reg(REG_DAMP, 48'hffffffffffff);
    write_reg(REG_STIFF, 48'hffffffffffff);
    write_reg(REG_DBAND, 48'hffffffffffff);
    write_reg(REG_LIMIT, 48'hffffffffffff);
    for (int i = 0; i < 4; i++) begin
      it = make_beat(i[0] ? OP_TICK : OP_FORCE, 1);
      send_beat(it, 0);
    end
    drain();
    write_reg(REG_DBAND, 48'd0);
    write_reg(REG_DAMP, 48'd0);
    write_reg(REG_STIFF, 48'd0);
    for (int i = 0; i < 4; i++) begin
      it = make_beat(i[0] ? OP_TICK : OP_FORCE, 1);
      send_beat(it, 0);
    end
    drain();
    write_reg(REG_MODE, 48'd0);
    send_beat(make_beat(OP_FORCE, 0), 0);
    send_beat(make_beat(OP_TICK, 0), 0);
    drain();

    // random phases, each with its own register setting
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_MODE, ph == 5 ? 48'd0 : 48'(ph % 4));
      write_reg(REG_BIASCNT, ph == 3 ? 48'hffff : 48'($urandom_range(0, 6)));
      write_reg(REG_DT, ph == 4 ? 48'hffffff : 48'($urandom_range(1, 200000)));
      write_reg(REG_IMASS, ph == 4 ? rand48() : {3{16'($urandom_range(0, 8192))}});
      write_reg(REG_DAMP, ph == 4 ? rand48() : {3{16'($urandom_range(0, 4000))}});
      write_reg(REG_STIFF, ph == 4 ? rand48() : {3{16'($urandom_range(0, 4000))}});
      write_reg(REG_DBAND, ph == 4 ? rand48() : {3{16'($urandom_range(0, 3000))}});
      write_reg(REG_LIMIT, ph == 4 ? rand48() : {3{16'($urandom_range(0, 65535))}});
      for (int i = 0; i < 250; i++) begin
        if (ph == 1 && i == 20) hold_off_req = 1;
        kind = $urandom_range(0, 19);
        if (kind == 0) it = make_beat(OP_UNUSED, 1);
        else if (kind < 3) it = make_beat(OP_TARGET, kind - 1);
        else if (kind < 10) it = make_beat(OP_FORCE, int'(kind == 9));
        else it = make_beat(OP_TICK, 0);
        send_beat(it, !in_long_hold && (i % 60) < 40);
        if (ph == 2 && i == 100) drain();
      end
      drain();
    end

    if (n_errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/cao_pkg.sv
sv/cao_div.sv
sv/cao_lane.sv
sv/cartesian_admittance_offset_top.sv
sv/cao_checker.sv
tb/cartesian_admittance_offset_top_test.sv
